>>> design/vpdl_pkg.sv
// ============================================================================
// VPD location parser package
// Tag codes, character codes and the result word shared by the parser files.
// ============================================================================
package vpdl_pkg;

  // Area tags of the VPD image.
  localparam logic [7:0] TAG_ID_STRING = 8'h82;
  localparam logic [7:0] TAG_VENDOR    = 8'h84;
  localparam logic [7:0] TAG_END       = 8'h79;

  // Two-character manufacturer tags, high byte first.
  localparam logic [15:0] MFG_FRAME_ID = 16'h4649;
  localparam logic [15:0] MFG_FORMAT   = 16'h4D46;
  localparam logic [15:0] MFG_SLOT_MAP = 16'h534D;

  // Slot map format that places one pad byte ahead of the first entry.
  localparam logic [15:0] SLOT_FMT_PADDED = 16'h1004;

  // Secondary id that a matching slot entry must carry.
  localparam logic [7:0] SLOT_SEC_ID = 8'h10;

  // Bridge id value that means no bridge is known.
  localparam logic [7:0] BRIDGE_NONE = 8'hFF;

  // Characters of the bus marker in the ID string.
  localparam logic [7:0] CHAR_B     = 8'h42;
  localparam logic [7:0] CHAR_U     = 8'h55;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  // Result word of one image.
  typedef struct packed {
    logic        status;
    logic [7:0]  bridge_id;
    logic [7:0]  frame_id;
    logic        frame_found;
    logic [23:0] card_location;
    logic        card_found;
  } vpdl_result_t;

endpackage

>>> design/vpdl_if.sv
// ============================================================================
// VPD location parser channels
// Valid/ready channels for the byte stream and for the result word.
// ============================================================================
interface vpdl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] vpd_byte;
  logic       last_byte;

  modport source (output valid, output vpd_byte, output last_byte, input ready);
  modport sink   (input valid, input vpd_byte, input last_byte, output ready);
endinterface

interface vpdl_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [7:0]  bridge_id;
  logic [7:0]  frame_id;
  logic        frame_found;
  logic [23:0] card_location;
  logic        card_found;

  modport source (output valid, output status, output bridge_id, output frame_id,
                  output frame_found, output card_location, output card_found,
                  input ready);
  modport sink   (input valid, input status, input bridge_id, input frame_id,
                  input frame_found, input card_location, input card_found,
                  output ready);
endinterface

>>> design/vpd_location_parser.sv
// ============================================================================
// VPD location parser
// Walks a bus VPD image byte by byte and reports bridge, frame and card slot.
// ============================================================================
// Usage:
// - in_ch carries one image byte per word; last_byte marks the final byte.
// - out_ch carries one result word per image, produced by the final byte.
// - cfg_wr_en/cfg_wr_data write the agent id; write it only while idle.
// - A byte is registered on acceptance and parsed from the input register;
//   the result word of a last byte is then registered in the result register.
// - One byte per cycle is sustained unless a last byte is held; the parse step
//   is one pass of logic between the input register and the result register.
// - If the receiver stalls, the held result stays valid and bytes that do
//   not end an image keep flowing; a second last byte waits in the input
//   register until the result register is free.
// - Reset clears both valid flags, the parser state and the agent id. After
//   each result the parser returns to its reset state for the next image.
// ============================================================================
module vpd_location_parser #(
  parameter int MAX_VPD_BYTES = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  vpdl_in_if.sink           in_ch,
  vpdl_out_if.source        out_ch,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data
);

  logic [7:0]             agent_r;
  logic                   in_vld_r;
  logic [7:0]             in_byte_r;
  logic                   in_last_r;
  logic                   out_vld_r;
  vpdl_pkg::vpdl_result_t res_r;
  vpdl_pkg::vpdl_result_t core_res;
  logic                   advance;

  // Agent id register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      agent_r <= 8'h00;
    end else if (cfg_wr_en) begin
      agent_r <= cfg_wr_data;
    end
  end

  // The held byte moves on unless it ends an image and the result slot is full.
  assign advance     = in_vld_r && (!in_last_r || !out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.vpd_byte;
      in_last_r <= in_ch.last_byte;
    end
  end

  vpdl_core #(
    .MAX_VPD_BYTES (MAX_VPD_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (advance),
    .vpd_byte  (in_byte_r),
    .last_byte (in_last_r),
    .agent_id  (agent_r),
    .res       (core_res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (advance && in_last_r) begin
      res_r <= core_res;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.status        = res_r.status;
  assign out_ch.bridge_id     = res_r.bridge_id;
  assign out_ch.frame_id      = res_r.frame_id;
  assign out_ch.frame_found   = res_r.frame_found;
  assign out_ch.card_location = res_r.card_location;
  assign out_ch.card_found    = res_r.card_found;

endmodule

>>> design/vpdl_core.sv
// ============================================================================
// VPD location parser core
// Parser state for one image; consumes one byte per enabled cycle and shows
// the result word that the byte would give if it ends the image.
// ============================================================================
module vpdl_core #(
  parameter int MAX_VPD_BYTES = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic [7:0]            vpd_byte,
  input  logic                  last_byte,
  input  logic [7:0]            agent_id,
  output vpdl_pkg::vpdl_result_t res
);

  localparam int LEN_W = $clog2(MAX_VPD_BYTES + 1);
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_VPD_BYTES);

  typedef enum logic [2:0] {
    PH_START, PH_TAG, PH_HEADER, PH_BODY, PH_DONE, PH_ERROR
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER, KIND_ID, KIND_VENDOR
  } kind_t;

  phase_t             phase_r, phase_nxt;
  kind_t              kind_r, kind_nxt;
  logic               hdr_second_r, hdr_second_nxt;
  logic [7:0]         hdr_low_r, hdr_low_nxt;
  logic [LEN_W-1:0]   area_rem_r, area_rem_nxt;
  logic [LEN_W-1:0]   byte_cnt_r, byte_cnt_nxt;
  logic [7:0]         mfg_rem_r, mfg_rem_nxt;
  logic [15:0]        mfg_tag_r, mfg_tag_nxt;
  logic [7:0]         entry_pos_r, entry_pos_nxt;
  logic [15:0]        slot_fmt_r, slot_fmt_nxt;
  logic [3:0]         slot_idx_r, slot_idx_nxt;
  logic [23:0]        slot_chars_r, slot_chars_nxt;
  logic               slot_pad_r, slot_pad_nxt;
  logic               slot_hit_r, slot_hit_nxt;
  logic               slot_done_r, slot_done_nxt;
  logic [2:0]         bus_prog_r, bus_prog_nxt;
  logic [7:0]         bridge_r, bridge_nxt;
  logic [7:0]         frame_r, frame_nxt;
  logic               frame_found_r, frame_found_nxt;
  logic [23:0]        loc_r, loc_nxt;
  logic               loc_found_r, loc_found_nxt;

  logic [15:0]        len_full;
  logic [7:0]         bridge_pick;

  assign len_full    = {vpd_byte, hdr_low_r};
  assign bridge_pick = (bridge_r == vpdl_pkg::BRIDGE_NONE) ? vpd_byte : bridge_r;

  // Next state for one consumed byte.
  always_comb begin
    phase_nxt       = phase_r;
    kind_nxt        = kind_r;
    hdr_second_nxt  = hdr_second_r;
    hdr_low_nxt     = hdr_low_r;
    area_rem_nxt    = area_rem_r;
    byte_cnt_nxt    = byte_cnt_r;
    mfg_rem_nxt     = mfg_rem_r;
    mfg_tag_nxt     = mfg_tag_r;
    entry_pos_nxt   = entry_pos_r;
    slot_fmt_nxt    = slot_fmt_r;
    slot_idx_nxt    = slot_idx_r;
    slot_chars_nxt  = slot_chars_r;
    slot_pad_nxt    = slot_pad_r;
    slot_hit_nxt    = slot_hit_r;
    slot_done_nxt   = slot_done_r;
    bus_prog_nxt    = bus_prog_r;
    bridge_nxt      = bridge_r;
    frame_nxt       = frame_r;
    frame_found_nxt = frame_found_r;
    loc_nxt         = loc_r;
    loc_found_nxt   = loc_found_r;

    // Bytes past the size limit are ignored.
    if (byte_cnt_r < MAX_LEN) begin
      byte_cnt_nxt = byte_cnt_r + LEN_W'(1);
      case (phase_r)
        PH_START: begin
          if (vpd_byte != vpdl_pkg::TAG_ID_STRING) begin
            phase_nxt = PH_ERROR;
          end else begin
            kind_nxt       = KIND_ID;
            hdr_second_nxt = 1'b0;
            phase_nxt      = PH_HEADER;
          end
        end
        PH_TAG: begin
          if (vpd_byte == vpdl_pkg::TAG_END) begin
            phase_nxt = PH_DONE;
          end else begin
            if (vpd_byte == vpdl_pkg::TAG_ID_STRING) begin
              kind_nxt = KIND_ID;
            end else if (vpd_byte == vpdl_pkg::TAG_VENDOR) begin
              kind_nxt = KIND_VENDOR;
            end else begin
              kind_nxt = KIND_OTHER;
            end
            hdr_second_nxt = 1'b0;
            phase_nxt      = PH_HEADER;
          end
        end
        PH_HEADER: begin
          if (!hdr_second_r) begin
            hdr_low_nxt    = vpd_byte;
            hdr_second_nxt = 1'b1;
          end else begin
            // Little-endian length, saturated at the image size limit.
            if ({1'b0, len_full} > 17'(MAX_VPD_BYTES)) begin
              area_rem_nxt = MAX_LEN;
            end else begin
              area_rem_nxt = LEN_W'(len_full);
            end
            hdr_second_nxt = 1'b0;
            if (kind_r == KIND_ID) begin
              bridge_nxt   = vpdl_pkg::BRIDGE_NONE;
              bus_prog_nxt = 3'd0;
            end else if (kind_r == KIND_VENDOR) begin
              slot_fmt_nxt  = '0;
              entry_pos_nxt = '0;
              mfg_rem_nxt   = '0;
              mfg_tag_nxt   = '0;
            end
            phase_nxt = (len_full == 16'd0) ? PH_TAG : PH_BODY;
          end
        end
        PH_BODY: begin
          if (kind_r == KIND_ID) begin
            // Search for the bus marker, skip spaces, take the id nibble.
            if (bus_prog_r == 3'd4) begin
              bus_prog_nxt = bus_prog_r;
            end else if (bus_prog_r == 3'd3) begin
              if (vpd_byte != vpdl_pkg::CHAR_SPACE) begin
                bridge_nxt   = {4'h0, vpd_byte[3:0]};
                bus_prog_nxt = 3'd4;
              end
            end else if (bus_prog_r == 3'd1 && vpd_byte == vpdl_pkg::CHAR_U) begin
              bus_prog_nxt = 3'd2;
            end else if (bus_prog_r == 3'd2 && vpd_byte == vpdl_pkg::CHAR_S) begin
              bus_prog_nxt = 3'd3;
            end else begin
              bus_prog_nxt = (vpd_byte == vpdl_pkg::CHAR_B) ? 3'd1 : 3'd0;
            end
          end else if (kind_r == KIND_VENDOR) begin
            // Manufacturer entries: tag high, tag low, length, data.
            if (entry_pos_r == 8'd0) begin
              mfg_tag_nxt   = {vpd_byte, 8'h00};
              entry_pos_nxt = 8'd1;
            end else if (entry_pos_r == 8'd1) begin
              mfg_tag_nxt   = {mfg_tag_r[15:8], vpd_byte};
              entry_pos_nxt = 8'd2;
            end else if (entry_pos_r == 8'd2) begin
              mfg_rem_nxt   = vpd_byte;
              entry_pos_nxt = (vpd_byte == 8'd0) ? 8'd0 : 8'd3;
              if (mfg_tag_r == vpdl_pkg::MFG_SLOT_MAP) begin
                slot_idx_nxt   = '0;
                slot_chars_nxt = '0;
                slot_hit_nxt   = 1'b0;
                slot_done_nxt  = 1'b0;
                slot_pad_nxt   = (slot_fmt_r == vpdl_pkg::SLOT_FMT_PADDED);
              end
            end else begin
              if (mfg_tag_r == vpdl_pkg::MFG_FRAME_ID) begin
                if (entry_pos_r == 8'd3) begin
                  frame_nxt       = vpd_byte;
                  frame_found_nxt = 1'b1;
                end
              end else if (mfg_tag_r == vpdl_pkg::MFG_FORMAT) begin
                if (entry_pos_r == 8'd3) begin
                  slot_fmt_nxt = {vpd_byte, 8'h00};
                end else if (entry_pos_r == 8'd4) begin
                  slot_fmt_nxt = {slot_fmt_r[15:8], vpd_byte};
                end
              end else if (mfg_tag_r == vpdl_pkg::MFG_SLOT_MAP) begin
                // One byte of the 16-byte slot entries.
                if (!slot_done_r) begin
                  if (slot_pad_r) begin
                    slot_pad_nxt = 1'b0;
                  end else begin
                    case (slot_idx_r)
                      4'd0: slot_hit_nxt = (vpd_byte == agent_id);
                      4'd1: slot_hit_nxt = slot_hit_r && (vpd_byte == vpdl_pkg::SLOT_SEC_ID);
                      4'd2: begin
                        if (slot_hit_r) begin
                          bridge_nxt   = bridge_pick;
                          slot_hit_nxt = (vpd_byte == bridge_pick);
                        end
                      end
                      4'd3: slot_chars_nxt = {16'h0000, vpd_byte};
                      4'd4: slot_chars_nxt = {slot_chars_r[15:0], vpd_byte};
                      4'd5: begin
                        slot_chars_nxt = {slot_chars_r[15:0], vpd_byte};
                        if (slot_hit_r) begin
                          loc_nxt       = {slot_chars_r[15:0], vpd_byte};
                          loc_found_nxt = 1'b1;
                          slot_done_nxt = 1'b1;
                        end
                      end
                      default: slot_hit_nxt = slot_hit_r;
                    endcase
                    slot_idx_nxt = slot_idx_r + 4'd1;
                  end
                end
              end
              if (entry_pos_r != 8'hFF) begin
                entry_pos_nxt = entry_pos_r + 8'd1;
              end
              mfg_rem_nxt = mfg_rem_r - 8'd1;
              if (mfg_rem_r == 8'd1) begin
                entry_pos_nxt = 8'd0;
              end
            end
          end
          area_rem_nxt = area_rem_r - LEN_W'(1);
          if (area_rem_r == LEN_W'(1)) begin
            phase_nxt = PH_TAG;
          end
        end
        default: phase_nxt = phase_r;
      endcase
    end
  end

  // Result word as it stands after this byte.
  always_comb begin
    if (phase_nxt == PH_ERROR) begin
      res.status        = 1'b1;
      res.bridge_id     = vpdl_pkg::BRIDGE_NONE;
      res.frame_id      = 8'h00;
      res.frame_found   = 1'b0;
      res.card_location = 24'h000000;
      res.card_found    = 1'b0;
    end else begin
      res.status        = 1'b0;
      res.bridge_id     = bridge_nxt;
      res.frame_id      = frame_nxt;
      res.frame_found   = frame_found_nxt;
      res.card_location = loc_nxt;
      res.card_found    = loc_found_nxt;
    end
  end

  // Parser state; the last byte of an image returns it to reset.
  always_ff @(posedge clk) begin
    if (!rst_n || (en && last_byte)) begin
      phase_r       <= PH_START;
      kind_r        <= KIND_OTHER;
      hdr_second_r  <= 1'b0;
      hdr_low_r     <= 8'h00;
      area_rem_r    <= '0;
      byte_cnt_r    <= '0;
      mfg_rem_r     <= 8'h00;
      mfg_tag_r     <= 16'h0000;
      entry_pos_r   <= 8'h00;
      slot_fmt_r    <= 16'h0000;
      slot_idx_r    <= 4'h0;
      slot_chars_r  <= 24'h000000;
      slot_pad_r    <= 1'b0;
      slot_hit_r    <= 1'b0;
      slot_done_r   <= 1'b0;
      bus_prog_r    <= 3'd0;
      bridge_r      <= vpdl_pkg::BRIDGE_NONE;
      frame_r       <= 8'h00;
      frame_found_r <= 1'b0;
      loc_r         <= 24'h000000;
      loc_found_r   <= 1'b0;
    end else if (en) begin
      phase_r       <= phase_nxt;
      kind_r        <= kind_nxt;
      hdr_second_r  <= hdr_second_nxt;
      hdr_low_r     <= hdr_low_nxt;
      area_rem_r    <= area_rem_nxt;
      byte_cnt_r    <= byte_cnt_nxt;
      mfg_rem_r     <= mfg_rem_nxt;
      mfg_tag_r     <= mfg_tag_nxt;
      entry_pos_r   <= entry_pos_nxt;
      slot_fmt_r    <= slot_fmt_nxt;
      slot_idx_r    <= slot_idx_nxt;
      slot_chars_r  <= slot_chars_nxt;
      slot_pad_r    <= slot_pad_nxt;
      slot_hit_r    <= slot_hit_nxt;
      slot_done_r   <= slot_done_nxt;
      bus_prog_r    <= bus_prog_nxt;
      bridge_r      <= bridge_nxt;
      frame_r       <= frame_nxt;
      frame_found_r <= frame_found_nxt;
      loc_r         <= loc_nxt;
      loc_found_r   <= loc_found_nxt;
    end
  end

endmodule

>>> design/vpdl_checker.sv
// ============================================================================
// VPD location parser checker
// Port-level assertions on the result channel, bound to the top level.
// ============================================================================
module vpdl_port_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        status,
  input logic [7:0]  bridge_id,
  input logic [7:0]  frame_id,
  input logic        frame_found,
  input logic [23:0] card_location,
  input logic        card_found
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // No result word right after reset.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word offered after reset");

  // A bad start tag reports no bridge, frame or card.
  a_error_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status |-> bridge_id == vpdl_pkg::BRIDGE_NONE && !frame_found &&
    frame_id == 8'h00 && !card_found && card_location == 24'h000000)
    else $error("error word carries parse data");

  // Fields without a find are zero.
  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (frame_found || frame_id == 8'h00) &&
    (card_found || card_location == 24'h000000))
    else $error("field set without a find");

endmodule

bind vpd_location_parser vpdl_port_checker u_vpdl_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .status        (out_ch.status),
  .bridge_id     (out_ch.bridge_id),
  .frame_id      (out_ch.frame_id),
  .frame_found   (out_ch.frame_found),
  .card_location (out_ch.card_location),
  .card_found    (out_ch.card_found)
);

>>> tb/sv/vpdl_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// VPD location parser result checker
// Watches the byte and result channels. It predicts the result word of every
// image and compares each result word with it, field by field.
// ============================================================================
module vpdl_checker #(
  parameter int MAX_VPD_BYTES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  vpdl_in_if         in_ch,
  vpdl_out_if        out_ch,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         fail_count,
  output int         pending,
  output int         checked
);
  import vpdl_pkg::*;

  typedef enum logic [3:0] {
    SCAN_START, SCAN_TAG, SCAN_HEADER, SCAN_BODY, SCAN_DONE, SCAN_ERROR
  } scan_phase_e;

  typedef enum logic [1:0] {AREA_OTHER, AREA_ID, AREA_VENDOR} area_kind_e;

  // Progress through the bus marker of the ID string.
  typedef enum logic [2:0] {MARK_IDLE, MARK_B, MARK_BU, MARK_BUS, MARK_TAKEN} bus_mark_e;

  // Byte positions inside one slot entry, and the first data byte of a mfg entry.
  localparam logic [3:0] SLOT_AGENT  = 4'd0;
  localparam logic [3:0] SLOT_SEC    = 4'd1;
  localparam logic [3:0] SLOT_BRIDGE = 4'd2;
  localparam logic [3:0] SLOT_CHAR0  = 4'd3;
  localparam logic [3:0] SLOT_CHAR1  = 4'd4;
  localparam logic [3:0] SLOT_CHAR2  = 4'd5;
  localparam logic [7:0] MFG_DATA_START = 8'd3;

  // Predicted parser state.
  logic [7:0]   agent;
  scan_phase_e  phase;
  logic [16:0]  area_left;
  logic         hdr_high;
  area_kind_e   kind;
  logic [7:0]   mfg_left;
  logic [15:0]  mfg_tag;
  logic [7:0]   mfg_pos;
  logic [15:0]  slot_fmt;
  logic [3:0]   slot_idx;
  logic [23:0]  slot_chars;
  bus_mark_e    mark;
  logic [7:0]   bridge;
  logic [8:0]   frame;
  logic [24:0]  location;
  int unsigned  byte_cnt;
  bit           slot_pad;
  bit           slot_hit;
  bit           slot_done;

  vpdl_result_t result_q[$];
  int           mismatches;
  int           words_checked;

  function automatic void clear_image();
    phase      = SCAN_START;
    area_left  = '0;
    hdr_high   = 1'b0;
    kind       = AREA_OTHER;
    mfg_left   = '0;
    mfg_tag    = '0;
    mfg_pos    = '0;
    slot_fmt   = '0;
    slot_idx   = '0;
    slot_chars = '0;
    mark       = MARK_IDLE;
    bridge     = BRIDGE_NONE;
    frame      = '0;
    location   = '0;
    byte_cnt   = 0;
    slot_pad   = 1'b0;
    slot_hit   = 1'b0;
    slot_done  = 1'b0;
  endfunction

  // One image byte through the area walk.
  function automatic void scan_byte(input logic [7:0] b);
    int         total;
    logic [7:0] idx;
    case (phase)
      SCAN_START: begin
        if (b != TAG_ID_STRING) begin
          phase = SCAN_ERROR;
        end else begin
          kind     = AREA_ID;
          hdr_high = 1'b0;
          phase    = SCAN_HEADER;
        end
      end
      SCAN_TAG: begin
        if (b == TAG_END) begin
          phase = SCAN_DONE;
        end else begin
          kind = (b == TAG_ID_STRING) ? AREA_ID :
                 ((b == TAG_VENDOR) ? AREA_VENDOR : AREA_OTHER);
          hdr_high = 1'b0;
          phase    = SCAN_HEADER;
        end
      end
      SCAN_HEADER: begin
        if (!hdr_high) begin
          area_left = {9'd0, b};
          hdr_high  = 1'b1;
        end else begin
          // The length is little endian and saturates at the image limit.
          total = int'(area_left) + (int'(b) << 8);
          if (total > MAX_VPD_BYTES) total = MAX_VPD_BYTES;
          area_left = 17'(total);
          hdr_high  = 1'b0;
          if (kind == AREA_ID) begin
            bridge = BRIDGE_NONE;
            mark   = MARK_IDLE;
          end else if (kind == AREA_VENDOR) begin
            slot_fmt = '0;
            mfg_pos  = '0;
            mfg_left = '0;
            mfg_tag  = '0;
          end
          phase = (area_left == 0) ? SCAN_TAG : SCAN_BODY;
        end
      end
      SCAN_BODY: begin
        if (kind == AREA_ID) begin
          // Look for the bus marker, skip spaces, then take the low nibble.
          if (mark == MARK_BUS) begin
            if (b != CHAR_SPACE) begin
              bridge = {4'h0, b[3:0]};
              mark   = MARK_TAKEN;
            end
          end else if (mark != MARK_TAKEN) begin
            if (mark == MARK_B && b == CHAR_U) mark = MARK_BU;
            else if (mark == MARK_BU && b == CHAR_S) mark = MARK_BUS;
            else mark = (b == CHAR_B) ? MARK_B : MARK_IDLE;
          end
        end else if (kind == AREA_VENDOR) begin
          // Mfg entries: two tag bytes, a length byte, then data.
          if (mfg_pos == 8'd0) begin
            mfg_tag = {b, 8'h00};
            mfg_pos = 8'd1;
          end else if (mfg_pos == 8'd1) begin
            mfg_tag[7:0] = b;
            mfg_pos      = 8'd2;
          end else if (mfg_pos == 8'd2) begin
            mfg_left = b;
            mfg_pos  = (b == 8'd0) ? 8'd0 : MFG_DATA_START;
            if (mfg_tag == MFG_SLOT_MAP) begin
              slot_idx   = '0;
              slot_chars = '0;
              slot_hit   = 1'b0;
              slot_done  = 1'b0;
              slot_pad   = (slot_fmt == SLOT_FMT_PADDED);
            end
          end else begin
            idx = mfg_pos - MFG_DATA_START;
            if (mfg_tag == MFG_FRAME_ID) begin
              if (idx == 8'd0) frame = {1'b1, b};
            end else if (mfg_tag == MFG_FORMAT) begin
              if (idx == 8'd0) slot_fmt = {b, 8'h00};
              else if (idx == 8'd1) slot_fmt[7:0] = b;
            end else if (mfg_tag == MFG_SLOT_MAP && !slot_done) begin
              if (slot_pad) begin
                slot_pad = 1'b0;
              end else begin
                case (slot_idx)
                  SLOT_AGENT: slot_hit = (b == agent);
                  SLOT_SEC:   slot_hit = slot_hit && (b == SLOT_SEC_ID);
                  SLOT_BRIDGE: begin
                    // With no bridge known, the entry adopts its own.
                    if (slot_hit) begin
                      if (bridge == BRIDGE_NONE) bridge = b;
                      slot_hit = (b == bridge);
                    end
                  end
                  SLOT_CHAR0: slot_chars = {16'h0000, b};
                  SLOT_CHAR1: slot_chars = {slot_chars[15:0], b};
                  SLOT_CHAR2: begin
                    slot_chars = {slot_chars[15:0], b};
                    if (slot_hit) begin
                      location  = {1'b1, slot_chars};
                      slot_done = 1'b1;
                    end
                  end
                  default: ;
                endcase
                slot_idx = slot_idx + 4'd1;
              end
            end
            if (mfg_pos != 8'hFF) mfg_pos = mfg_pos + 8'd1;
            mfg_left = mfg_left - 8'd1;
            if (mfg_left == 8'd0) mfg_pos = 8'd0;
          end
        end
        area_left = area_left - 17'd1;
        if (area_left == 0) phase = SCAN_TAG;
      end
      default: ;
    endcase
  endfunction

  function automatic int check_field(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Prediction on every accepted byte, comparison on every accepted result.
  always @(posedge clk) begin : watch
    vpdl_result_t r;
    vpdl_result_t w;
    if (!rst_n) begin
      agent = 8'h00;
      clear_image();
      result_q.delete();
    end else begin
      if (cfg_wr_en) agent = cfg_wr_data;

      if (in_ch.valid && in_ch.ready) begin
        // Bytes past the image limit are dropped, but last_byte still counts.
        if (byte_cnt < MAX_VPD_BYTES) begin
          byte_cnt++;
          scan_byte(in_ch.vpd_byte);
        end
        if (in_ch.last_byte) begin
          r = '0;
          if (phase == SCAN_ERROR) begin
            r.status    = 1'b1;
            r.bridge_id = BRIDGE_NONE;
          end else begin
            r.bridge_id     = bridge;
            r.frame_id      = frame[7:0];
            r.frame_found   = frame[8];
            r.card_location = location[23:0];
            r.card_found    = location[24];
          end
          result_q.push_back(r);
          clear_image();
        end
      end

      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $error("result word arrived with no image outstanding");
          mismatches++;
        end else begin
          w = result_q.pop_front();
          mismatches += check_field("status", 32'(w.status), 32'(out_ch.status));
          mismatches += check_field("bridge_id", 32'(w.bridge_id),
                                    32'(out_ch.bridge_id));
          mismatches += check_field("frame_id", 32'(w.frame_id),
                                    32'(out_ch.frame_id));
          mismatches += check_field("frame_found", 32'(w.frame_found),
                                    32'(out_ch.frame_found));
          mismatches += check_field("card_location", 32'(w.card_location),
                                    32'(out_ch.card_location));
          mismatches += check_field("card_found", 32'(w.card_found),
                                    32'(out_ch.card_found));
          words_checked++;
        end
      end
    end
    fail_count <= mismatches;
    pending    <= result_q.size();
    checked    <= words_checked;
  end

endmodule

>>> tb/sv/tb_vpd_location_parser.sv
`timescale 1ns / 1ps
// ============================================================================
// VPD location parser testbench
// Feeds short directed images and then random VPD images (well formed, cut
// off, overlong and noise) under several agent ids, with random gaps and
// stalls on both channels. A separate checker predicts and compares.
// ============================================================================
module tb_vpd_location_parser;
  import vpdl_pkg::*;

  localparam int MAX_BYTES    = 1024;
  localparam int NUM_PHASES   = 6;
  localparam int PHASE_BYTES  = 160;
  localparam int PHASE_IMAGES = 4;
  localparam int MAX_GAP      = 17;
  localparam int SETTLE       = 4;
  localparam int DRAIN        = 8;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_IMAGE   = 1040;

  logic       clk;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;

  vpdl_in_if  in_ch();
  vpdl_out_if out_ch();

  int fail_count;
  int pending;
  int checked;

  bit          rush;
  int          bytes_sent;
  int          images_sent;
  int          idle_cycles;
  logic [7:0]  agent_cfg;
  logic [7:0]  bridge_hint;
  bit          padded_hint;
  logic [7:0]  img[$];
  logic [7:0]  body[$];
  logic [7:0]  entry[$];

  vpd_location_parser #(.MAX_VPD_BYTES(MAX_BYTES)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  vpdl_checker #(.MAX_VPD_BYTES(MAX_BYTES)) u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Ends the run when neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("vpd_location_parser verification failed");
        $finish;
      end
    end
  end

  // Result side: a random stall before each result word.
  initial begin : receiver
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      gap = rush ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // Mostly printable characters, sometimes any byte.
  function automatic logic [7:0] text_byte();
    return ($urandom_range(0, 3) == 0) ? rand_byte() : 8'($urandom_range(32, 90));
  endfunction

  // Appends an area header and the body; the length is sometimes wrong.
  function automatic void put_area(input logic [7:0] tag);
    logic [15:0] len;
    len = 16'(body.size());
    case ($urandom_range(0, 19))
      0: len = 16'($urandom);
      1: len = len + 16'($urandom_range(1, 3));
      2: len = (len > 2) ? len - 16'd2 : 16'd0;
      default: ;
    endcase
    img.push_back(tag);
    img.push_back(len[7:0]);
    img.push_back(len[15:8]);
    foreach (body[i]) img.push_back(body[i]);
  endfunction

  function automatic void build_id_body();
    int         n;
    logic [7:0] id;
    body.delete();
    n = $urandom_range(0, 5);
    repeat (n) body.push_back(text_byte());
    if ($urandom_range(0, 9) < 8) begin
      // An occasional false start ahead of the real marker.
      if ($urandom_range(0, 4) == 0) begin
        body.push_back(CHAR_B);
        body.push_back(CHAR_U);
      end
      body.push_back(CHAR_B);
      body.push_back(CHAR_U);
      body.push_back(CHAR_S);
      n = $urandom_range(0, 3);
      repeat (n) body.push_back(CHAR_SPACE);
      if ($urandom_range(0, 9) != 0) begin
        id = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(48, 57)) : rand_byte();
        body.push_back(id);
        bridge_hint = {4'h0, id[3:0]};
      end
    end
    n = $urandom_range(0, 4);
    repeat (n) body.push_back(text_byte());
  endfunction

  function automatic void build_vendor_body();
    int          n;
    int          k;
    int          r;
    logic [7:0]  len;
    logic [7:0]  d0;
    logic [7:0]  d1;
    logic [15:0] tag;
    body.delete();
    padded_hint = 1'b0;
    n = $urandom_range(1, 4);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0: begin
          body.push_back(MFG_FRAME_ID[15:8]);
          body.push_back(MFG_FRAME_ID[7:0]);
          len = 8'($urandom_range(0, 3));
          body.push_back(len);
          repeat (len) body.push_back(rand_byte());
        end
        1: begin
          d0 = ($urandom_range(0, 9) < 7) ? SLOT_FMT_PADDED[15:8] : rand_byte();
          d1 = ($urandom_range(0, 9) < 7) ? SLOT_FMT_PADDED[7:0] : rand_byte();
          len = 8'($urandom_range(0, 3));
          body.push_back(MFG_FORMAT[15:8]);
          body.push_back(MFG_FORMAT[7:0]);
          body.push_back(len);
          if (len >= 1) body.push_back(d0);
          if (len >= 2) body.push_back(d1);
          if (len >= 3) body.push_back(rand_byte());
          if (len != 0) padded_hint = (len >= 2) && ({d0, d1} == SLOT_FMT_PADDED);
        end
        2, 3: begin
          // Slot map: optional pad byte, then 16-byte entries.
          entry.delete();
          if (padded_hint ^ ($urandom_range(0, 9) == 0)) entry.push_back(rand_byte());
          k = $urandom_range(0, 2);
          repeat (k) begin
            entry.push_back(($urandom_range(0, 3) != 0) ? agent_cfg : rand_byte());
            entry.push_back(($urandom_range(0, 4) != 0) ? SLOT_SEC_ID : rand_byte());
            r = $urandom_range(0, 9);
            entry.push_back((r < 5) ? bridge_hint :
                            ((r < 7) ? BRIDGE_NONE : {4'h0, 4'($urandom)}));
            repeat (3) entry.push_back(text_byte());
            repeat (10) entry.push_back(rand_byte());
          end
          len = 8'(entry.size());
          if ($urandom_range(0, 6) == 0) len = 8'($urandom_range(0, len));
          body.push_back(MFG_SLOT_MAP[15:8]);
          body.push_back(MFG_SLOT_MAP[7:0]);
          body.push_back(len);
          foreach (entry[i]) body.push_back(entry[i]);
        end
        default: begin
          tag = 16'($urandom);
          len = 8'($urandom_range(0, 4));
          body.push_back(tag[15:8]);
          body.push_back(tag[7:0]);
          body.push_back(len);
          repeat (len) body.push_back(rand_byte());
        end
      endcase
    end
  endfunction

  // One random image: noise, a bad start tag, or a walk of areas.
  function automatic void build_image();
    int         sel;
    int         n;
    int         k;
    int         r;
    logic [7:0] v;
    img.delete();
    bridge_hint = BRIDGE_NONE;
    sel = $urandom_range(0, 99);
    if (sel < 12) begin
      if ($urandom_range(0, 2) == 0) img.push_back(TAG_ID_STRING);
      n = $urandom_range(1, 24);
      repeat (n) img.push_back(rand_byte());
    end else begin
      build_id_body();
      put_area(TAG_ID_STRING);
      k = $urandom_range(0, 3);
      repeat (k) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          build_vendor_body();
          put_area(TAG_VENDOR);
        end else if (r < 8) begin
          build_id_body();
          put_area(TAG_ID_STRING);
        end else begin
          body.delete();
          n = $urandom_range(0, 6);
          repeat (n) body.push_back(rand_byte());
          put_area(rand_byte());
        end
      end
      if ($urandom_range(0, 4) != 0) img.push_back(TAG_END);
      n = $urandom_range(0, 3);
      repeat (n) img.push_back(rand_byte());
      if (sel < 22) begin
        do v = rand_byte(); while (v == TAG_ID_STRING);
        img[0] = v;
      end
      // Some images end before their areas do.
      if ($urandom_range(0, 6) == 0) begin
        n = $urandom_range(1, img.size());
        img = img[0:n-1];
      end
    end
  endfunction

  // Sender side: one byte per word, a random gap before each.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = rush ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     = 1'b1;
    in_ch.vpd_byte  = b;
    in_ch.last_byte = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_image();
    foreach (img[i]) send_byte(img[i], i == img.size() - 1);
    images_sent++;
  endtask

  // Holds the sender off until every result word has come back.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [7:0] agents[NUM_PHASES];
    int         phase_start;
    int         phase_images;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = 8'h00;
    in_ch.valid     = 1'b0;
    in_ch.vpd_byte  = 8'h00;
    in_ch.last_byte = 1'b0;
    rush            = 1'b0;
    bytes_sent      = 0;
    images_sent     = 0;
    agent_cfg       = 8'h00;
    bridge_hint     = BRIDGE_NONE;
    padded_hint     = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Both extremes of the agent id first, then random ones.
    agents[0] = 8'h00;
    agents[1] = 8'hFF;
    for (int i = 2; i < NUM_PHASES; i++) agents[i] = rand_byte();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) drain();
      cfg_wr_en   = 1'b1;
      cfg_wr_data = agents[p];
      agent_cfg   = agents[p];
      @(negedge clk);
      cfg_wr_en = 1'b0;
      rush = (p % 2 == 1);

      if (p == 0) begin
        // Bad start tag, a bare start tag, a bridge id behind spaces,
        // and a frame id in an image that ends with its vendor area and no end tag.
        img = '{8'h00};
        send_image();
        img = '{TAG_ID_STRING};
        send_image();
        img = '{TAG_ID_STRING, 8'h06, 8'h00, CHAR_B, CHAR_U, CHAR_S, CHAR_SPACE,
                CHAR_SPACE, 8'hFF, TAG_END};
        send_image();
        img = '{TAG_ID_STRING, 8'h00, 8'h00, TAG_VENDOR, 8'h04, 8'h00,
                MFG_FRAME_ID[15:8], MFG_FRAME_ID[7:0], 8'h01, 8'hFF};
        send_image();
      end

      phase_start  = bytes_sent;
      phase_images = 0;
      while (bytes_sent - phase_start < PHASE_BYTES || phase_images < PHASE_IMAGES) begin
        if ($urandom_range(0, 19) == 0) drain();
        if (p == 3 && phase_images == 2) begin
          // Overlong image whose area length saturates at the image limit.
          img.delete();
          img = '{TAG_ID_STRING, 8'hFF, 8'hFF, CHAR_B, CHAR_U, CHAR_S, CHAR_SPACE,
                  8'h37};
          while (img.size() < LONG_IMAGE) img.push_back(rand_byte());
        end else begin
          build_image();
        end
        if (p % 2 == 0) rush = ($urandom_range(0, 9) == 0);
        send_image();
        phase_images++;
      end
    end

    in_ch.valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Sent %0d bytes in %0d images under %0d agent id settings;",
             bytes_sent, images_sent, NUM_PHASES);
    $display("%0d result words were compared.", checked);
    if (fail_count == 0) begin
      $display("vpd_location_parser verification clean");
    end else begin
      $display("vpd_location_parser verification failed");
    end
    $finish;
  end

endmodule
